/* hdl/u2r_pkg.sv */
// ----------------------------------------------------------------------------
// u2r_pkg
// Shared types and constants for the UTF-8 to RTF unicode escape block.
// ----------------------------------------------------------------------------
package u2r_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CP_W       = 16;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned MAX_DIGITS = 5;
    localparam int unsigned CNT_W      = 3;

    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'd128;
    localparam logic [BYTE_W-1:0] LEAD3_MIN   = 8'd224;
    localparam logic [CP_W-1:0]   BOM_POINT   = 16'd65279;
    localparam logic [CP_W-1:0]   RAW_MAX     = 16'd127;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;
    localparam logic [1:0] EXP_NONE  = 2'd1;
    localparam logic [1:0] EXP_TWO   = 2'd2;
    localparam logic [1:0] EXP_THREE = 2'd3;

    localparam logic [CNT_W-1:0] HEAD_LAST = 3'd6;

    // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x
    localparam logic [CP_W-1:0] DIV10_MUL   = 16'd52429;
    localparam int unsigned     DIV10_SHIFT = 19;

    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_CLOSE = 8'h7D;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RAW,
        PH_HEAD,
        PH_DIGIT,
        PH_CLOSE
    } ph_t;

    typedef struct packed {
        logic            is_esc;
        logic [CP_W-1:0] cp;
    } job_t;

    // \uc0{\u
    function automatic logic [BYTE_W-1:0] head_byte(input logic [CNT_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = 8'h5C;
            3'd1:    b = 8'h75;
            3'd2:    b = 8'h63;
            3'd3:    b = 8'h30;
            3'd4:    b = 8'h7B;
            3'd5:    b = 8'h5C;
            3'd6:    b = 8'h75;
            default: b = 8'h5C;
        endcase
        return b;
    endfunction

endpackage

/* hdl/u2r_emit.sv */
// ----------------------------------------------------------------------------
// u2r_emit
// Serializes one code point per item into output bytes: a raw byte, or the
// escape header, decimal digits and closing brace. Digits are extracted one
// per cycle while the header streams out.
// ----------------------------------------------------------------------------
module u2r_emit
    import u2r_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  job_t              job,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              run_last
);

    ph_t                ph_reg, ph_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CP_W-1:0]    val_reg, val_next;
    logic [CNT_W-1:0]   ndig_reg, ndig_next;
    logic [DIGIT_W-1:0] dig_reg [MAX_DIGITS];

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              run_last_reg;

    logic              adv;
    logic              load;
    logic              div_busy;
    logic [2*CP_W-1:0] prod;
    logic [CP_W-1:0]   quot;
    logic [CP_W-1:0]   rem_full;
    logic              emit_go;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last;

    assign adv       = !out_valid_reg || out_ready;
    assign job_ready = (ph_reg == PH_IDLE)
                    || (((ph_reg == PH_RAW) || (ph_reg == PH_CLOSE)) && adv);
    assign load      = job_valid && job_ready;

    // divide by ten via reciprocal multiply
    assign prod     = val_reg * DIV10_MUL;
    assign quot     = CP_W'(prod >> DIV10_SHIFT);
    assign rem_full = val_reg - ((quot << 3) + (quot << 1));
    assign div_busy = (ph_reg == PH_HEAD) && (val_reg != '0)
                   && (ndig_reg != CNT_W'(MAX_DIGITS));

    always_comb
    begin
        ph_next  = ph_reg;
        cnt_next = cnt_reg;
        case (ph_reg)
            PH_IDLE:
            begin
                if (load)
                begin
                    ph_next  = job.is_esc ? PH_HEAD : PH_RAW;
                    cnt_next = '0;
                end
            end
            PH_RAW, PH_CLOSE:
            begin
                if (load)
                begin
                    ph_next  = job.is_esc ? PH_HEAD : PH_RAW;
                    cnt_next = '0;
                end
                else if (adv)
                begin
                    ph_next = PH_IDLE;
                end
            end
            PH_HEAD:
            begin
                if (adv)
                begin
                    if (cnt_reg == HEAD_LAST)
                    begin
                        ph_next  = PH_DIGIT;
                        cnt_next = ndig_reg - CNT_W'(1);
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            PH_DIGIT:
            begin
                if (adv)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        ph_next = PH_CLOSE;
                    end
                end
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        emit_go   = (ph_reg != PH_IDLE) && adv;
        emit_byte = val_reg[BYTE_W-1:0];
        emit_last = 1'b0;
        case (ph_reg)
            PH_RAW:
            begin
                emit_byte = val_reg[BYTE_W-1:0];
                emit_last = 1'b1;
            end
            PH_HEAD:
            begin
                emit_byte = head_byte(cnt_reg);
            end
            PH_DIGIT:
            begin
                emit_byte = CHAR_ZERO + BYTE_W'(dig_reg[cnt_reg]);
            end
            PH_CLOSE:
            begin
                emit_byte = CHAR_CLOSE;
                emit_last = 1'b1;
            end
            default:
            begin
                emit_byte = val_reg[BYTE_W-1:0];
            end
        endcase
    end

    always_comb
    begin
        val_next  = val_reg;
        ndig_next = ndig_reg;
        if (load)
        begin
            val_next  = job.cp;
            ndig_next = '0;
        end
        else if (div_busy)
        begin
            val_next  = quot;
            ndig_next = ndig_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= PH_IDLE;
            cnt_reg       <= '0;
            ndig_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            cnt_reg  <= cnt_next;
            ndig_reg <= ndig_next;
            if (adv)
            begin
                out_valid_reg <= emit_go;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (!load && div_busy)
        begin
            dig_reg[ndig_reg] <= rem_full[DIGIT_W-1:0];
        end
        if (emit_go)
        begin
            out_byte_reg <= emit_byte;
            run_last_reg <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

endmodule

/* hdl/utf8_to_rtf_unicode_escape.sv */
// ----------------------------------------------------------------------------
// utf8_to_rtf_unicode_escape
// UTF-8 byte stream in, RTF unicode escaped text bytes out.
// ----------------------------------------------------------------------------
// Each input item is one UTF-8 byte. An ASCII byte gives one output byte; a
// lead or middle byte of an open sequence gives none; the closing byte gives
// one raw byte, nothing for a byte order mark, or \uc0{\u, three to five
// decimal digits and } (eleven to thirteen bytes). The output serializer
// sends one byte per cycle while out_ready is high and takes the next item as
// it sends the last byte of the current one; run_last marks the final output
// byte of each item.
// ----------------------------------------------------------------------------
module utf8_to_rtf_unicode_escape
    import u2r_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              run_last
);

    logic [BYTE_W-1:0] first_reg, first_next;
    logic [BYTE_W-1:0] second_reg, second_next;
    logic [1:0]        held_reg, held_next;
    logic [1:0]        exp_reg, exp_next;

    logic       accept;
    logic [1:0] exp_eff;
    logic [CP_W-1:0] cp;
    logic       has_job;
    job_t       job;
    logic       job_ready;

    assign accept  = in_valid && in_ready;
    assign exp_eff = (held_reg == HELD_NONE) ? ((in_byte < LEAD3_MIN) ? EXP_TWO : EXP_THREE)
                                             : exp_reg;

    always_comb
    begin
        if (exp_eff == EXP_THREE)
        begin
            cp = {first_reg[3:0], second_reg[5:0], in_byte[5:0]};
        end
        else
        begin
            cp = {5'd0, first_reg[4:0], in_byte[5:0]};
        end
    end

    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        held_next   = held_reg;
        exp_next    = exp_reg;
        has_job     = 1'b0;
        job.is_esc  = 1'b0;
        job.cp      = {8'd0, in_byte};
        if (in_byte < ASCII_LIMIT)
        begin
            has_job = 1'b1;
        end
        else if (held_reg == HELD_NONE)
        begin
            first_next = in_byte;
            held_next  = HELD_ONE;
            exp_next   = exp_eff;
        end
        else if ((held_reg == HELD_ONE) && (exp_eff == EXP_THREE))
        begin
            second_next = in_byte;
            held_next   = HELD_TWO;
        end
        else
        begin
            held_next  = HELD_NONE;
            exp_next   = EXP_NONE;
            has_job    = (cp != BOM_POINT);
            job.is_esc = (cp > RAW_MAX);
            job.cp     = cp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
            held_reg   <= HELD_NONE;
            exp_reg    <= EXP_NONE;
        end
        else if (accept)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            held_reg   <= held_next;
            exp_reg    <= exp_next;
        end
    end

    assign in_ready = job_ready;

    u2r_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (in_valid && has_job),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule

/* verif/tb_utf8_to_rtf_unicode_escape.sv */
// ----------------------------------------------------------------------------
// tb_utf8_to_rtf_unicode_escape
// Self-checking bench for the UTF-8 to RTF unicode escape block.
// ----------------------------------------------------------------------------
// Feeds UTF-8 bytes over the input handshake and checks every output byte and
// its run_last flag against a behavioral decoder or typed table text. A short
// table covers ASCII extremes, the byte order mark, the largest code point,
// overlong forms, ASCII inside an open sequence, a stray continuation byte
// and a four-byte lead. Random traffic follows: mostly well-formed sequences,
// with broken sequences and noise mixed in. Both sides stall in random
// bursts, except in the closing stretch of the run.
// ----------------------------------------------------------------------------
module tb_utf8_to_rtf_unicode_escape;
    import u2r_pkg::*;

    localparam int DIR_N      = 24;
    localparam int RAND_ITEMS = 300;
    localparam int QUIET_TAIL = 40;
    localparam int DRAIN_CYC  = 20;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } rtf_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] in_byte;
    logic              out_valid;
    logic              out_ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;

    // decoder state
    logic [BYTE_W-1:0] lead_b;
    logic [BYTE_W-1:0] mid_b;
    logic [1:0]        held_cnt;
    logic [1:0]        want_cnt;

    rtf_t  fresh_q[$];
    rtf_t  rtf_q[$];
    bit    cur_typed;
    string cur_txt;
    bit    quiet;
    int    err_cnt;
    int    items_fed;
    int    bytes_checked;
    int    escapes_made;
    int    boms_dropped;

    // directed stimulus: input byte, whether the output is typed in, typed output
    logic [BYTE_W-1:0] dir_in [DIR_N] = '{
        8'h41, 8'h00, 8'h7F, 8'hEF, 8'hBB, 8'hBF, 8'hFF, 8'hFF,
        8'hFF, 8'hC2, 8'h80, 8'hC0, 8'h80, 8'hC1, 8'hBF, 8'hE0,
        8'h41, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hF0, 8'h90, 8'h80
    };
    bit dir_typed [DIR_N] = '{
        1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
        1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
    };
    string dir_txt [DIR_N] = '{
        "A", "", "", "", "", "", "", "",
        "\\uc0{\\u65535}", "", "\\uc0{\\u128}", "", "", "", "", "",
        "A", "", "", "", "?", "", "", "\\uc0{\\u1024}"
    };

    utf8_to_rtf_unicode_escape dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_err(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        err_cnt++;
    endtask

    function automatic void push_text(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++)
            fresh_q.insert(fresh_q.size(), rtf_t'{txt[i], i == txt.len() - 1});
    endfunction

    function automatic void put_point(input logic [CP_W-1:0] cp);
        int unsigned v;
        v = 32'(cp);
        if (cp == BOM_POINT)
            boms_dropped++;
        else if (cp > RAW_MAX)
        begin
            escapes_made++;
            push_text($sformatf("\\uc0{\\u%0d}", v));
        end
        else
            fresh_q.insert(fresh_q.size(), rtf_t'{cp[BYTE_W-1:0], 1'b1});
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        logic [CP_W-1:0] cp;
        if (b < ASCII_LIMIT)
        begin
            put_point({8'h00, b});
            return;
        end
        if (held_cnt == HELD_NONE)
        begin
            want_cnt = (b < LEAD3_MIN) ? EXP_TWO : EXP_THREE;
            lead_b   = b;
            held_cnt = HELD_ONE;
            return;
        end
        if (held_cnt == HELD_ONE && want_cnt == EXP_THREE)
        begin
            mid_b    = b;
            held_cnt = HELD_TWO;
            return;
        end
        if (want_cnt == EXP_THREE)
            cp = {lead_b[3:0], mid_b[5:0], b[5:0]};
        else
            cp = {5'd0, lead_b[4:0], b[5:0]};
        held_cnt = HELD_NONE;
        want_cnt = EXP_NONE;
        put_point(cp);
    endfunction

    // predict on input items, check output items
    always @(posedge clk)
    begin
        rtf_t exp_r;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                fresh_q.delete();
                decode_byte(in_byte);
                if (cur_typed)
                begin
                    fresh_q.delete();
                    push_text(cur_txt);
                end
                while (fresh_q.size() != 0)
                    rtf_q.insert(rtf_q.size(), fresh_q.pop_front());
            end
            if (out_valid && out_ready)
            begin
                bytes_checked++;
                if (rtf_q.size() == 0)
                    report_err($sformatf("output byte %02h with nothing expected", out_byte));
                else
                begin
                    exp_r = rtf_q.pop_front();
                    if (out_byte !== exp_r.ch)
                        report_err($sformatf("out_byte %02h, expected %02h",
                                             out_byte, exp_r.ch));
                    if (run_last !== exp_r.last)
                        report_err($sformatf("run_last %b, expected %b on byte %02h",
                                             run_last, exp_r.last, exp_r.ch));
                end
            end
        end
    end

    // output side stalls in bursts
    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                stall = $urandom_range(1, 12) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input string txt);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_typed = typed;
        cur_txt   = txt;
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        items_fed++;
    endtask

    function automatic logic [BYTE_W-1:0] cont_byte();
        return 8'h80 | BYTE_W'($urandom_range(0, 63));
    endfunction

    task automatic send_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            send_byte(BYTE_W'($urandom_range(0, 127)), 1'b0, "");
        else if (pick < 45)
        begin
            send_byte(BYTE_W'($urandom_range(8'hC0, 8'hDF)), 1'b0, "");
            send_byte(cont_byte(), 1'b0, "");
        end
        else if (pick < 75)
        begin
            send_byte(BYTE_W'($urandom_range(8'hE0, 8'hFF)), 1'b0, "");
            send_byte(cont_byte(), 1'b0, "");
            send_byte(cont_byte(), 1'b0, "");
        end
        else if (pick < 80)
        begin
            send_byte(8'hEF, 1'b0, "");
            send_byte(8'hBB, 1'b0, "");
            send_byte(8'hBF, 1'b0, "");
        end
        else if (pick < 88)
        begin
            // ASCII inside an open three-byte sequence
            send_byte(BYTE_W'($urandom_range(8'hE0, 8'hFF)), 1'b0, "");
            send_byte(BYTE_W'($urandom_range(0, 127)), 1'b0, "");
            send_byte(cont_byte(), 1'b0, "");
            send_byte(BYTE_W'($urandom_range(0, 127)), 1'b0, "");
            send_byte(cont_byte(), 1'b0, "");
        end
        else if (pick < 94)
        begin
            // truncated sequence: the next high byte closes it
            send_byte(BYTE_W'($urandom_range(8'h80, 8'hFF)), 1'b0, "");
            send_byte(BYTE_W'($urandom_range(0, 127)), 1'b0, "");
        end
        else
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, "");
    endtask

    initial
    begin
        int  i;
        bit  paused;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_byte   = '0;
        out_ready = 1'b0;
        quiet     = 1'b0;
        paused    = 1'b0;
        cur_typed = 1'b0;
        cur_txt   = "";
        err_cnt   = 0;
        items_fed = 0;
        bytes_checked = 0;
        escapes_made  = 0;
        boms_dropped  = 0;
        lead_b    = '0;
        mid_b     = '0;
        held_cnt  = HELD_NONE;
        want_cnt  = EXP_NONE;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < DIR_N; i++)
            send_byte(dir_in[i], dir_typed[i], dir_txt[i]);

        while (items_fed < DIR_N + RAND_ITEMS)
        begin
            if (!paused && items_fed >= DIR_N + RAND_ITEMS / 2)
            begin
                // hold input until the output side has drained
                paused = 1'b1;
                in_valid <= 1'b0;
                @(negedge clk);
                while (rtf_q.size() != 0) @(negedge clk);
            end
            if (items_fed >= DIR_N + RAND_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            send_char();
        end
        in_valid <= 1'b0;

        while (rtf_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Fed %0d UTF-8 bytes and checked %0d RTF bytes;", items_fed, bytes_checked);
        $display("%0d code points escaped, %0d byte order marks dropped.",
                 escapes_made, boms_dropped);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("ERROR: run timed out with %0d output bytes pending", rtf_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
